/* hw/rtl/icmp_erc_pkg.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply checker package
// Widths, limits, register indexes, verdict codes and the ones'-complement add.
// ----------------------------------------------------------------------------
package icmp_erc_pkg;

    localparam int MAX_REPLY_BYTES = 64;
    localparam int MIN_REPLY_BYTES = 8;
    localparam int COUNT_W         = $clog2(MAX_REPLY_BYTES + 1);

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_IDENTIFIER = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_SEQUENCE   = CFG_INDEX_W'(1);

    localparam logic [15:0] ECHO_IDENTIFIER_RESET = 16'd1;
    localparam logic [7:0]  ECHO_SEQUENCE_RESET   = 8'd1;
    localparam logic [15:0] SUM_GOOD              = 16'hffff;

    localparam logic [2:0] FAIL_NONE      = 3'd0;
    localparam logic [2:0] FAIL_SHORT     = 3'd1;
    localparam logic [2:0] FAIL_TYPE_CODE = 3'd2;
    localparam logic [2:0] FAIL_IDENT     = 3'd3;
    localparam logic [2:0] FAIL_SEQ       = 3'd4;
    localparam logic [2:0] FAIL_SUM       = 3'd5;

    // 16-bit ones'-complement add with end-around carry
    function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

/* hw/rtl/icmp_echo_reply_checker.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply checker
// Sums and checks the first 64 bytes of one ICMP message, gives one verdict.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata: rx_byte, s_tlast: end_of_message
//  m_      | out | m_tvalid / m_tready  | m_tdata: reply_ok, fail_reason
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One byte per cycle while s_tready is high; each transfer updates the count,
//  hold byte and sum in the cycle it is accepted, and the final byte's verdict
//  is registered next.
//  aresetn is synchronous: clears the message state, the output valid and
//  loads the register defaults.
//  s_tready drops only while a verdict waits and m_tready is low.
module icmp_echo_reply_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] reply_ok, [3:1] fail_reason, [7:4] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [icmp_erc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [icmp_erc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [icmp_erc_pkg::COUNT_W-1:0] MAX_CNT =
        icmp_erc_pkg::COUNT_W'(icmp_erc_pkg::MAX_REPLY_BYTES);
    localparam logic [icmp_erc_pkg::COUNT_W-1:0] MIN_CNT =
        icmp_erc_pkg::COUNT_W'(icmp_erc_pkg::MIN_REPLY_BYTES);

    logic [15:0] echo_identifier_reg;
    logic [7:0]  echo_sequence_reg;

    logic [icmp_erc_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0] ones_sum_reg, ones_sum_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;
    logic [2:0]  first_error_reg, first_error_next;

    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg, m_tdata_next;

    logic        s_fire;
    logic        kept;
    logic        odd_pos;
    logic [2:0]  byte_error;
    logic [15:0] word;
    logic [15:0] sum_final;
    logic [2:0]  verdict;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign kept    = byte_count_reg < MAX_CNT;
    assign odd_pos = byte_count_reg[0];

    always_comb begin
        byte_error = icmp_erc_pkg::FAIL_NONE;
        if (kept) begin
            case (byte_count_reg)
                icmp_erc_pkg::COUNT_W'(0), icmp_erc_pkg::COUNT_W'(1): begin
                    if (s_tdata != 8'd0) byte_error = icmp_erc_pkg::FAIL_TYPE_CODE;
                end
                icmp_erc_pkg::COUNT_W'(4): begin
                    if (s_tdata != echo_identifier_reg[15:8])
                        byte_error = icmp_erc_pkg::FAIL_IDENT;
                end
                icmp_erc_pkg::COUNT_W'(5): begin
                    if (s_tdata != echo_identifier_reg[7:0])
                        byte_error = icmp_erc_pkg::FAIL_IDENT;
                end
                icmp_erc_pkg::COUNT_W'(7): begin
                    if (s_tdata != echo_sequence_reg) byte_error = icmp_erc_pkg::FAIL_SEQ;
                end
                default: byte_error = icmp_erc_pkg::FAIL_NONE;
            endcase
        end
    end

    always_comb begin
        byte_count_next     = byte_count_reg;
        high_byte_hold_next = high_byte_hold_reg;
        ones_sum_next       = ones_sum_reg;
        first_error_next    = first_error_reg;
        if (kept) begin
            byte_count_next = byte_count_reg + icmp_erc_pkg::COUNT_W'(1);
            if (odd_pos) begin
                ones_sum_next = icmp_erc_pkg::add_ones(ones_sum_reg,
                                                       {high_byte_hold_reg, s_tdata});
            end else begin
                high_byte_hold_next = s_tdata;
            end
            if (first_error_reg == icmp_erc_pkg::FAIL_NONE) begin
                first_error_next = byte_error;
            end
        end
    end

    // word that closes the sum on the marked byte; an odd tail is padded low
    always_comb begin
        if (kept) begin
            word = odd_pos ? {high_byte_hold_reg, s_tdata} : {s_tdata, 8'd0};
        end else begin
            word = odd_pos ? {high_byte_hold_reg, 8'd0} : 16'd0;
        end
        sum_final = icmp_erc_pkg::add_ones(ones_sum_reg, word);
    end

    always_comb begin
        if (byte_count_next < MIN_CNT) begin
            verdict = icmp_erc_pkg::FAIL_SHORT;
        end else if (first_error_next != icmp_erc_pkg::FAIL_NONE) begin
            verdict = first_error_next;
        end else if (sum_final != icmp_erc_pkg::SUM_GOOD) begin
            verdict = icmp_erc_pkg::FAIL_SUM;
        end else begin
            verdict = icmp_erc_pkg::FAIL_NONE;
        end
        m_tdata_next = {4'd0, verdict, (verdict == icmp_erc_pkg::FAIL_NONE)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_identifier_reg <= icmp_erc_pkg::ECHO_IDENTIFIER_RESET;
            echo_sequence_reg   <= icmp_erc_pkg::ECHO_SEQUENCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                icmp_erc_pkg::REG_ECHO_IDENTIFIER: echo_identifier_reg <= cfg_data[15:0];
                icmp_erc_pkg::REG_ECHO_SEQUENCE:   echo_sequence_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            ones_sum_reg       <= '0;
            high_byte_hold_reg <= '0;
            first_error_reg    <= icmp_erc_pkg::FAIL_NONE;
        end else if (s_fire) begin
            if (s_tlast) begin
                byte_count_reg     <= '0;
                ones_sum_reg       <= '0;
                high_byte_hold_reg <= '0;
                first_error_reg    <= icmp_erc_pkg::FAIL_NONE;
            end else begin
                byte_count_reg     <= byte_count_next;
                ones_sum_reg       <= ones_sum_next;
                high_byte_hold_reg <= high_byte_hold_next;
                first_error_reg    <= first_error_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire && s_tlast) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tlast) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_ok_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == icmp_erc_pkg::FAIL_NONE)))
        else $error("reply_ok disagrees with fail_reason");

    a_reason_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= icmp_erc_pkg::FAIL_SUM && m_tdata[7:4] == 4'd0))
        else $error("fail_reason out of range");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (byte_count_reg == '0 && ones_sum_reg == 16'd0
                                 && first_error_reg == icmp_erc_pkg::FAIL_NONE))
        else $error("message state not cleared after verdict");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= MAX_CNT)
        else $error("byte count past limit");

endmodule

/* sim/tb_icmp_echo_reply_checker.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply checker testbench
// Streams ICMP messages byte by byte into the checker, predicts each verdict
// from a cycle-free model of the header checks and the ones'-complement sum,
// and compares every result transfer in order. Covers defaults, register
// extremes, short, odd, overlong and all-zero messages, header faults,
// random noise and a long output stall.
// ----------------------------------------------------------------------------
module tb_icmp_echo_reply_checker;

    localparam logic [icmp_erc_pkg::CFG_INDEX_W-1:0] REG_UNUSED =
        icmp_erc_pkg::CFG_INDEX_W'(15);
    localparam int RANDOM_BYTES = 520;

    typedef struct packed {
        logic       reply_ok;
        logic [2:0] fail_reason;
    } verdict_t;

    typedef enum int {
        FLAW_NONE, FLAW_TYPE, FLAW_CODE, FLAW_IDENT_HI, FLAW_IDENT_LO, FLAW_SEQ, FLAW_SUM
    } flaw_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [7:0]                           s_tdata   = 8'h00;
    logic                                 s_tlast   = 1'b0;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [7:0]                           m_tdata;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [icmp_erc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [icmp_erc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    icmp_echo_reply_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model state
    logic [15:0] want_ident = icmp_erc_pkg::ECHO_IDENTIFIER_RESET;
    logic [7:0]  want_seq   = icmp_erc_pkg::ECHO_SEQUENCE_RESET;
    int          kept_bytes = 0;
    logic [15:0] run_sum    = '0;
    logic [7:0]  pend_hi    = '0;
    logic [2:0]  header_err = icmp_erc_pkg::FAIL_NONE;

    verdict_t    expected_verdicts[$];
    logic [7:0]  msg_buf[$];
    int          errors       = 0;
    int          bytes_sent   = 0;
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    int          hold_request = 0;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + 16'(s[16]);
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [15:0] total;
        logic [2:0]  code;
        verdict_t    v;
        if (kept_bytes < icmp_erc_pkg::MAX_REPLY_BYTES) begin
            if (header_err == icmp_erc_pkg::FAIL_NONE) begin
                if ((kept_bytes == 0 || kept_bytes == 1) && b != 8'h00)
                    header_err = icmp_erc_pkg::FAIL_TYPE_CODE;
                else if (kept_bytes == 4 && b != want_ident[15:8])
                    header_err = icmp_erc_pkg::FAIL_IDENT;
                else if (kept_bytes == 5 && b != want_ident[7:0])
                    header_err = icmp_erc_pkg::FAIL_IDENT;
                else if (kept_bytes == 7 && b != want_seq)
                    header_err = icmp_erc_pkg::FAIL_SEQ;
            end
            if (kept_bytes % 2 == 0)
                pend_hi = b;
            else
                run_sum = ones_add(run_sum, {pend_hi, b});
            kept_bytes++;
        end
        if (last) begin
            total = run_sum;
            if (kept_bytes % 2 == 1)
                total = ones_add(total, {pend_hi, 8'h00});
            if (kept_bytes < icmp_erc_pkg::MIN_REPLY_BYTES)
                code = icmp_erc_pkg::FAIL_SHORT;
            else if (header_err != icmp_erc_pkg::FAIL_NONE)
                code = header_err;
            else if (total != icmp_erc_pkg::SUM_GOOD)
                code = icmp_erc_pkg::FAIL_SUM;
            else
                code = icmp_erc_pkg::FAIL_NONE;
            v.reply_ok    = (code == icmp_erc_pkg::FAIL_NONE);
            v.fail_reason = code;
            expected_verdicts.push_back(v);
            kept_bytes = 0;
            run_sum    = '0;
            pend_hi    = '0;
            header_err = icmp_erc_pkg::FAIL_NONE;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_buf.size(); i++)
            send_byte(msg_buf[i], i == msg_buf.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [icmp_erc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [icmp_erc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == icmp_erc_pkg::REG_ECHO_IDENTIFIER)
            want_ident = data;
        else if (idx == icmp_erc_pkg::REG_ECHO_SEQUENCE)
            want_seq = data[7:0];
        @(posedge aclk);
    endtask

    // well-formed reply with valid checksum, then one optional fault
    task automatic build_reply(input int len, input flaw_t flaw);
        int          kept;
        int          idx;
        logic [15:0] s;
        logic [7:0]  flip;
        msg_buf.delete();
        for (int i = 0; i < len; i++)
            msg_buf.push_back(8'($urandom));
        for (int i = 0; i < 4 && i < len; i++)
            msg_buf[i] = 8'h00;
        if (len > 4) msg_buf[4] = want_ident[15:8];
        if (len > 5) msg_buf[5] = want_ident[7:0];
        if (len > 7) msg_buf[7] = want_seq;
        kept = (len < icmp_erc_pkg::MAX_REPLY_BYTES) ? len : icmp_erc_pkg::MAX_REPLY_BYTES;
        s = '0;
        for (int i = 0; i < kept; i += 2)
            s = ones_add(s, {msg_buf[i], (i + 1 < kept) ? msg_buf[i + 1] : 8'h00});
        s = ~s;
        if (len > 2) msg_buf[2] = s[15:8];
        if (len > 3) msg_buf[3] = s[7:0];
        flip = 8'(1 << $urandom_range(0, 7));
        if (len >= icmp_erc_pkg::MIN_REPLY_BYTES) begin
            case (flaw)
                FLAW_TYPE:     msg_buf[0] ^= flip;
                FLAW_CODE:     msg_buf[1] ^= flip;
                FLAW_IDENT_HI: msg_buf[4] ^= flip;
                FLAW_IDENT_LO: msg_buf[5] ^= flip;
                FLAW_SEQ:      msg_buf[7] ^= flip;
                FLAW_SUM: begin
                    idx = (kept > 8 && $urandom_range(0, 1)) ? $urandom_range(8, kept - 1) : 6;
                    msg_buf[idx] ^= flip;
                end
                default: ;
            endcase
        end
    endtask

    task automatic test_good_reply();
        build_reply(8, FLAW_NONE);
        send_message();
    endtask

    task automatic test_short_message();
        msg_buf = {8'hff, 8'hff, 8'h00};
        send_message();
    endtask

    task automatic test_register_extremes();
        drain();
        write_reg(icmp_erc_pkg::REG_ECHO_IDENTIFIER, 16'hffff);
        write_reg(icmp_erc_pkg::REG_ECHO_SEQUENCE, 16'hffff);
        write_reg(REG_UNUSED, 16'h0000);
        build_reply(9, FLAW_NONE);
        send_message();
    endtask

    task automatic test_all_zero();
        drain();
        write_reg(icmp_erc_pkg::REG_ECHO_IDENTIFIER, 16'h0000);
        write_reg(icmp_erc_pkg::REG_ECHO_SEQUENCE, 16'h0000);
        msg_buf.delete();
        for (int i = 0; i < 8; i++)
            msg_buf.push_back(8'h00);
        send_message();
    endtask

    task automatic test_output_stall();
        drain();
        src_idle_on  = 1'b0;
        hold_request = 200;
        for (int n = 0; n < 6; n++) begin
            build_reply(8, FLAW_NONE);
            send_message();
        end
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_replies();
        int    r;
        int    len;
        flaw_t flaw;
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin
                    write_reg(icmp_erc_pkg::REG_ECHO_IDENTIFIER, 16'($urandom));
                    write_reg(icmp_erc_pkg::REG_ECHO_SEQUENCE, 16'($urandom));
                end
                1: begin
                    write_reg(icmp_erc_pkg::REG_ECHO_IDENTIFIER, 16'hffff);
                    write_reg(icmp_erc_pkg::REG_ECHO_SEQUENCE, 16'h00ff);
                end
                2: begin
                    write_reg(icmp_erc_pkg::REG_ECHO_IDENTIFIER, 16'h0000);
                    write_reg(icmp_erc_pkg::REG_ECHO_SEQUENCE, 16'h0000);
                end
                default: begin
                    write_reg(REG_UNUSED, 16'($urandom));
                    write_reg(icmp_erc_pkg::REG_ECHO_IDENTIFIER, 16'($urandom));
                    write_reg(icmp_erc_pkg::REG_ECHO_SEQUENCE, 16'($urandom));
                end
            endcase
            if (phase == 5) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            while (bytes_sent < 28 + 48 + (phase + 1) * RANDOM_BYTES / 6) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    msg_buf.delete();
                    len = $urandom_range(1, 16);
                    for (int i = 0; i < len; i++)
                        msg_buf.push_back(8'($urandom));
                end else begin
                    if (r < 18)
                        len = $urandom_range(1, 7);
                    else if (r < 24)
                        len = $urandom_range(60, 80);
                    else
                        len = $urandom_range(8, 40);
                    flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE
                         : flaw_t'($urandom_range(FLAW_TYPE, FLAW_SUM));
                    build_reply(len, flaw);
                end
                send_message();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_good_reply();
        test_short_message();
        test_register_extremes();
        test_all_zero();
        test_output_stall();
        test_random_replies();
        drain();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result sink: random stalls, one long hold on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else if (sink_idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result transfer, got %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want.reply_ok) begin
                    $display("%0t: reply_ok expected %0d got %0d",
                             $time, want.reply_ok, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[3:1] !== want.fail_reason) begin
                    $display("%0t: fail_reason expected %0d got %0d",
                             $time, want.fail_reason, m_tdata[3:1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/icmp_erc_pkg.sv
hw/rtl/icmp_echo_reply_checker.sv
sim/tb_icmp_echo_reply_checker.sv
